@@ rtl/lmq_pkg.sv @@
// Shared constants and codes for the linked multi-queue manager.
package lmq_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int ID_W        = 7;
    localparam int ENT_AW      = $clog2(NUM_ENTRIES);
    localparam int Q_DEPTH     = NUM_ENTRIES + 1;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int STEP_W      = $clog2(NUM_ENTRIES + 1);

    localparam logic [ID_W-1:0] NIL = ID_W'(NUM_ENTRIES);

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REM = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_BAD   = 2'd2;

endpackage

@@ rtl/lmq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/linked_multi_queue_manager.sv @@
// Top level: linked multi-queue manager with a sequenced link walker.
//
// NUM_ENTRIES+1 FIFO queues share one pool of NUM_ENTRIES entries, each
// entry holding a next and a prev link; the value NUM_ENTRIES is the null
// link. One beat in on the s_ channel (op, queue_id, thread_id) gives one
// beat out on the m_ channel (popped_id, status). The block works on one
// item at a time and drops s_ready while it is busy. A small sequencer
// drives three memories (head/tail pair per queue, next links, prev links),
// each with one write port and one registered read port. A bad argument
// goes straight to the result; every other command first reads the
// head/tail pair of its queue, and a remove on a queue of two or more
// entries then walks the next links from the head to the target. The
// walk stops after NUM_ENTRIES entries and reports not found. A
// finished result waits in an output register, so the next beat is taken
// while the previous result is still unclaimed. Per-entry valid bits
// clear at reset and an entry never written reads as null, so no
// clearing pass runs.
module linked_multi_queue_manager (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic [lmq_pkg::ID_W-1:0] s_queue_id,
    input  logic [lmq_pkg::ID_W-1:0] s_thread_id,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [lmq_pkg::ID_W-1:0] m_popped_id,
    output logic [1:0]               m_status
);

    localparam int W = lmq_pkg::ID_W;
    localparam int EA = lmq_pkg::ENT_AW;
    localparam int QA = lmq_pkg::Q_AW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QREAD,
        S_DECODE,
        S_ENQ2,
        S_DEQ2,
        S_WALK,
        S_WALKW,
        S_FOUND,
        S_CLR,
        S_DONE
    } state_t;

    state_t state_reg;

    // Latched command and walk context
    logic [1:0]              op_reg;
    logic [W-1:0]            q_reg;
    logic [W-1:0]            e_reg;
    logic [W-1:0]            h_reg;
    logic [W-1:0]            t_reg;
    logic [W-1:0]            cur_reg;
    logic [lmq_pkg::STEP_W-1:0] steps_reg;
    logic [W-1:0]            res_popped_reg;
    logic [1:0]              res_status_reg;

    // Output register
    logic                    m_valid_reg;
    logic [W-1:0]            m_popped_reg;
    logic [1:0]              m_status_reg;
    logic                    m_load;

    // Valid bits: an entry not yet written reads as null
    logic [lmq_pkg::NUM_ENTRIES:0]   qv_reg;
    logic [lmq_pkg::NUM_ENTRIES-1:0] nv_reg;
    logic [lmq_pkg::NUM_ENTRIES-1:0] pv_reg;
    logic                            qrd_null_reg;
    logic                            nrd_null_reg;
    logic                            prd_null_reg;

    // Memory ports
    logic            qw_en;
    logic [QA-1:0]   qw_addr;
    logic [2*W-1:0]  qw_data;
    logic [QA-1:0]   q_raddr;
    logic [2*W-1:0]  q_rdata;

    logic            nw_en;
    logic [EA-1:0]   nw_addr;
    logic [W-1:0]    nw_data;
    logic [W-1:0]    n_ridx;
    logic [EA-1:0]   n_raddr;
    logic [W-1:0]    n_rdata;

    logic            pw_en;
    logic [EA-1:0]   pw_addr;
    logic [W-1:0]    pw_data;
    logic [EA-1:0]   p_raddr;
    logic [W-1:0]    p_rdata;

    // Effective read values after null masking
    logic [W-1:0]    qh;
    logic [W-1:0]    qt;
    logic            q_empty;
    logic [W-1:0]    n_eff;
    logic [W-1:0]    p_eff;
    logic [W-1:0]    clr_idx;
    logic            bad_arg;
    logic            walk_end;

    assign qh      = qrd_null_reg ? lmq_pkg::NIL : q_rdata[2*W-1:W];
    assign qt      = qrd_null_reg ? lmq_pkg::NIL : q_rdata[W-1:0];
    assign q_empty = (qh == lmq_pkg::NIL) && (qt == lmq_pkg::NIL);
    assign n_eff   = nrd_null_reg ? lmq_pkg::NIL : n_rdata;
    assign p_eff   = prd_null_reg ? lmq_pkg::NIL : p_rdata;
    assign clr_idx = (op_reg == lmq_pkg::OP_DEQ) ? h_reg : e_reg;

    assign walk_end = (steps_reg == lmq_pkg::STEP_W'(lmq_pkg::NUM_ENTRIES))
                   || (cur_reg >= lmq_pkg::NIL);

    // Reject queue above the last one, entry out of range, or unused op
    assign bad_arg = (s_queue_id > lmq_pkg::NIL)
                  || (s_op != lmq_pkg::OP_ENQ && s_op != lmq_pkg::OP_DEQ
                      && s_op != lmq_pkg::OP_REM)
                  || (s_op != lmq_pkg::OP_DEQ && s_thread_id >= lmq_pkg::NIL);

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_popped_id = m_popped_reg;
    assign m_status    = m_status_reg;

    // Load the output register once it is empty or being drained this cycle
    assign m_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Read addresses: the link walk reads at the cursor, dequeue at the head
    assign q_raddr = q_reg[QA-1:0];
    assign n_ridx  = (state_reg == S_WALK) ? cur_reg : qh;
    assign n_raddr = n_ridx[EA-1:0];
    assign p_raddr = e_reg[EA-1:0];

    // Memory writes per sequencer step; a write through a null link is dropped
    always_comb begin
        qw_en   = 1'b0;
        qw_addr = q_reg[QA-1:0];
        qw_data = {lmq_pkg::NIL, lmq_pkg::NIL};
        nw_en   = 1'b0;
        nw_addr = e_reg[EA-1:0];
        nw_data = lmq_pkg::NIL;
        pw_en   = 1'b0;
        pw_addr = e_reg[EA-1:0];
        pw_data = lmq_pkg::NIL;
        unique case (state_reg)
            S_DECODE: begin
                unique case (op_reg)
                    lmq_pkg::OP_ENQ: begin
                        if (q_empty) begin
                            qw_en   = 1'b1;
                            qw_data = {e_reg, e_reg};
                            nw_en   = 1'b1;
                            pw_en   = 1'b1;
                        end else begin
                            // link old tail forward, new entry back
                            nw_en   = (qt < lmq_pkg::NIL);
                            nw_addr = qt[EA-1:0];
                            nw_data = e_reg;
                            pw_en   = 1'b1;
                            pw_data = qt;
                            qw_en   = 1'b1;
                            qw_data = {qh, e_reg};
                        end
                    end
                    lmq_pkg::OP_DEQ: begin
                        if (!q_empty && qh == qt) begin
                            qw_en   = 1'b1;
                            nw_en   = (qh < lmq_pkg::NIL);
                            nw_addr = qh[EA-1:0];
                            pw_en   = (qh < lmq_pkg::NIL);
                            pw_addr = qh[EA-1:0];
                        end
                    end
                    lmq_pkg::OP_REM: begin
                        if (!q_empty && qh == qt && qh == e_reg) begin
                            qw_en = 1'b1;
                            nw_en = 1'b1;
                            pw_en = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ENQ2: begin
                nw_en = 1'b1;
            end
            S_DEQ2: begin
                qw_en   = 1'b1;
                qw_data = {n_eff, t_reg};
                pw_en   = (n_eff < lmq_pkg::NIL);
                pw_addr = n_eff[EA-1:0];
            end
            S_FOUND: begin
                if (e_reg == h_reg) begin
                    qw_en   = 1'b1;
                    qw_data = {n_eff, t_reg};
                    pw_en   = (n_eff < lmq_pkg::NIL);
                    pw_addr = n_eff[EA-1:0];
                end else begin
                    nw_en   = (p_eff < lmq_pkg::NIL);
                    nw_addr = p_eff[EA-1:0];
                    nw_data = n_eff;
                    if (n_eff != lmq_pkg::NIL) begin
                        pw_en   = 1'b1;
                        pw_addr = n_eff[EA-1:0];
                        pw_data = p_eff;
                    end else begin
                        qw_en   = 1'b1;
                        qw_data = {h_reg, p_eff};
                    end
                end
            end
            S_CLR: begin
                nw_en   = (clr_idx < lmq_pkg::NIL);
                nw_addr = clr_idx[EA-1:0];
                pw_en   = (clr_idx < lmq_pkg::NIL);
                pw_addr = clr_idx[EA-1:0];
            end
            default: begin
            end
        endcase
    end

    lmq_ram #(.WIDTH(2 * W), .DEPTH(lmq_pkg::Q_DEPTH)) u_qptr_ram (
        .aclk  (aclk),
        .we    (qw_en),
        .waddr (qw_addr),
        .wdata (qw_data),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    lmq_ram #(.WIDTH(W), .DEPTH(lmq_pkg::NUM_ENTRIES)) u_next_ram (
        .aclk  (aclk),
        .we    (nw_en),
        .waddr (nw_addr),
        .wdata (nw_data),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    lmq_ram #(.WIDTH(W), .DEPTH(lmq_pkg::NUM_ENTRIES)) u_prev_ram (
        .aclk  (aclk),
        .we    (pw_en),
        .waddr (pw_addr),
        .wdata (pw_data),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Valid bits and null flags that travel with each registered read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg       <= '0;
            nv_reg       <= '0;
            pv_reg       <= '0;
            qrd_null_reg <= 1'b1;
            nrd_null_reg <= 1'b1;
            prd_null_reg <= 1'b1;
        end else begin
            if (qw_en) begin
                qv_reg[qw_addr] <= 1'b1;
            end
            if (nw_en) begin
                nv_reg[nw_addr] <= 1'b1;
            end
            if (pw_en) begin
                pv_reg[pw_addr] <= 1'b1;
            end
            qrd_null_reg <= !qv_reg[q_raddr];
            nrd_null_reg <= (n_ridx >= lmq_pkg::NIL) || !nv_reg[n_raddr];
            prd_null_reg <= !pv_reg[p_raddr];
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_op;
                        q_reg  <= s_queue_id;
                        e_reg  <= s_thread_id;
                        if (bad_arg) begin
                            res_popped_reg <= lmq_pkg::NIL;
                            res_status_reg <= lmq_pkg::STS_BAD;
                            state_reg      <= S_DONE;
                        end else begin
                            state_reg <= S_QREAD;
                        end
                    end
                end
                S_QREAD: begin
                    state_reg <= S_DECODE;
                end
                S_DECODE: begin
                    h_reg          <= qh;
                    t_reg          <= qt;
                    cur_reg        <= qh;
                    steps_reg      <= '0;
                    res_popped_reg <= lmq_pkg::NIL;
                    res_status_reg <= lmq_pkg::STS_OK;
                    unique case (op_reg)
                        lmq_pkg::OP_ENQ: begin
                            state_reg <= q_empty ? S_DONE : S_ENQ2;
                        end
                        lmq_pkg::OP_DEQ: begin
                            if (q_empty) begin
                                res_status_reg <= lmq_pkg::STS_EMPTY;
                                state_reg      <= S_DONE;
                            end else begin
                                res_popped_reg <= qh;
                                state_reg      <= (qh == qt) ? S_DONE : S_DEQ2;
                            end
                        end
                        lmq_pkg::OP_REM: begin
                            if (q_empty || (qh == qt && qh != e_reg)) begin
                                res_status_reg <= lmq_pkg::STS_EMPTY;
                                state_reg      <= S_DONE;
                            end else if (qh == qt) begin
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_WALK;
                            end
                        end
                        default: begin
                            res_status_reg <= lmq_pkg::STS_BAD;
                            state_reg      <= S_DONE;
                        end
                    endcase
                end
                S_ENQ2: begin
                    state_reg <= S_DONE;
                end
                S_DEQ2: begin
                    state_reg <= S_CLR;
                end
                S_WALK: begin
                    priority if (walk_end) begin
                        res_status_reg <= lmq_pkg::STS_EMPTY;
                        state_reg      <= S_DONE;
                    end else if (cur_reg == e_reg) begin
                        state_reg <= S_FOUND;
                    end else begin
                        state_reg <= S_WALKW;
                    end
                end
                S_WALKW: begin
                    cur_reg   <= n_eff;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_WALK;
                end
                S_FOUND: begin
                    state_reg <= S_CLR;
                end
                S_CLR: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (m_load) begin
                        m_popped_reg <= res_popped_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lmq_checker.sv @@
// Port-level assertions for the linked multi-queue manager, bound to the top.
module lmq_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [1:0]               s_op,
    input logic [lmq_pkg::ID_W-1:0] s_queue_id,
    input logic [lmq_pkg::ID_W-1:0] s_thread_id,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [lmq_pkg::ID_W-1:0] m_popped_id,
    input logic [1:0]               m_status
);

    // One item in flight: taking a beat drops ready on the next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat taken while an item is in progress");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_popped_id) && $stable(m_status)))
        else $error("result beat changed while stalled");

    // Only a successful dequeue returns a non-null entry
    a_popped_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != lmq_pkg::STS_OK) |-> (m_popped_id == lmq_pkg::NIL))
        else $error("entry returned with a failing status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == lmq_pkg::STS_OK || m_status == lmq_pkg::STS_EMPTY
                     || m_status == lmq_pkg::STS_BAD) && (m_popped_id <= lmq_pkg::NIL))
        else $error("result beat carries an undefined code");

    // A result needs an accepted item: none right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

endmodule

bind linked_multi_queue_manager lmq_checker u_lmq_checker (.*);

@@ tb/linked_multi_queue_manager_test.sv @@
// Self-checking testbench for the linked multi-queue manager.
`timescale 1ns / 1ps

module linked_multi_queue_manager_test;

    localparam int              NUM_ENTRIES = lmq_pkg::NUM_ENTRIES;
    localparam int              ID_W        = lmq_pkg::ID_W;
    localparam int              ENT_AW      = lmq_pkg::ENT_AW;
    localparam logic [ID_W-1:0] NIL         = lmq_pkg::NIL;
    localparam logic [1:0]      OP_ENQ      = lmq_pkg::OP_ENQ;
    localparam logic [1:0]      OP_DEQ      = lmq_pkg::OP_DEQ;
    localparam logic [1:0]      OP_REM      = lmq_pkg::OP_REM;
    localparam logic [1:0]      STS_OK      = lmq_pkg::STS_OK;
    localparam logic [1:0]      STS_EMPTY   = lmq_pkg::STS_EMPTY;
    localparam logic [1:0]      STS_BAD     = lmq_pkg::STS_BAD;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 1375;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 2 * NUM_ENTRIES + 16;
    localparam int WATCHDOG_LIMIT = 4000;

    // op 3 has no code in the package; it must be rejected as a bad argument
    localparam logic [1:0] OP_UNDEF = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0] popped;
        logic [1:0]      status;
    } outcome_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

    // Mirror of the queue pool: predicts one outcome per command beat, holds
    // the outcomes still owed by the block and checks each returned beat.
    class lmq_tracker;
        logic [ID_W-1:0] q_first [0:NUM_ENTRIES];
        logic [ID_W-1:0] q_last  [0:NUM_ENTRIES];
        logic [ID_W-1:0] fwd     [0:NUM_ENTRIES-1];
        logic [ID_W-1:0] bwd     [0:NUM_ENTRIES-1];
        logic [ID_W-1:0] owner   [0:NUM_ENTRIES-1];
        outcome_t        pending_outcomes[$];
        int errors, n_enq, n_deq, n_rem, n_rejected;
        int n_done, n_missing, n_pops, n_checked, deepest_walk;

        function new();
            foreach (q_first[i]) begin
                q_first[i] = NIL;
                q_last[i]  = NIL;
            end
            foreach (fwd[i]) begin
                fwd[i] = NIL;
                bwd[i] = NIL;
            end
        endfunction

        // Links through a null or out-of-range index read as null and
        // ignore writes.
        function logic [ID_W-1:0] fwd_of(logic [ID_W-1:0] i);
            return (i < NIL) ? fwd[i[ENT_AW-1:0]] : NIL;
        endfunction

        function logic [ID_W-1:0] bwd_of(logic [ID_W-1:0] i);
            return (i < NIL) ? bwd[i[ENT_AW-1:0]] : NIL;
        endfunction

        function void set_fwd(logic [ID_W-1:0] i, logic [ID_W-1:0] v);
            if (i < NIL) fwd[i[ENT_AW-1:0]] = v;
        endfunction

        function void set_bwd(logic [ID_W-1:0] i, logic [ID_W-1:0] v);
            if (i < NIL) bwd[i[ENT_AW-1:0]] = v;
        endfunction

        function void unlink(logic [ID_W-1:0] i);
            set_fwd(i, NIL);
            set_bwd(i, NIL);
        endfunction

        function logic [1:0] append_entry(logic [ID_W-1:0] qid, logic [ID_W-1:0] tid);
            if (q_first[qid] == NIL && q_last[qid] == NIL) begin
                q_first[qid] = tid;
                unlink(tid);
            end else begin
                set_fwd(q_last[qid], tid);
                set_bwd(tid, q_last[qid]);
                set_fwd(tid, NIL);
            end
            q_last[qid] = tid;
            return STS_OK;
        endfunction

        function logic [1:0] pop_head(logic [ID_W-1:0] qid, output logic [ID_W-1:0] popped);
            logic [ID_W-1:0] h, n;
            h = q_first[qid];
            popped = NIL;
            if (h == NIL && q_last[qid] == NIL) return STS_EMPTY;
            if (h == q_last[qid]) begin
                q_first[qid] = NIL;
                q_last[qid]  = NIL;
            end else begin
                n = fwd_of(h);
                set_bwd(n, NIL);
                q_first[qid] = n;
            end
            unlink(h);
            popped = h;
            return STS_OK;
        endfunction

        function logic [1:0] unlink_entry(logic [ID_W-1:0] qid, logic [ID_W-1:0] tid);
            logic [ID_W-1:0] h, cur, p, n;
            h = q_first[qid];
            if (h == NIL && q_last[qid] == NIL) return STS_EMPTY;
            if (h == q_last[qid]) begin
                if (h != tid) return STS_EMPTY;
                q_first[qid] = NIL;
                q_last[qid]  = NIL;
                unlink(tid);
                return STS_OK;
            end
            cur = h;
            // bounded walk: a corrupted list may loop back on itself
            for (int k = 0; k < NUM_ENTRIES && cur != NIL; k++) begin
                if (k + 1 > deepest_walk) deepest_walk = k + 1;
                if (cur == tid) begin
                    if (cur == h) begin
                        n = fwd_of(cur);
                        q_first[qid] = n;
                        set_bwd(n, NIL);
                    end else begin
                        p = bwd_of(cur);
                        n = fwd_of(cur);
                        set_fwd(p, n);
                        if (n != NIL) set_bwd(n, p);
                        else q_last[qid] = p;
                    end
                    unlink(tid);
                    return STS_OK;
                end
                cur = fwd_of(cur);
            end
            return STS_EMPTY;
        endfunction

        function outcome_t predict_outcome(logic [1:0] op, logic [ID_W-1:0] qid,
                                           logic [ID_W-1:0] tid);
            outcome_t res;
            logic [ID_W-1:0] popped;
            res.popped = NIL;
            res.status = STS_BAD;
            if (qid <= NIL) begin
                if (op == OP_ENQ && tid < NIL) begin
                    res.status = append_entry(qid, tid);
                end else if (op == OP_DEQ) begin
                    res.status = pop_head(qid, popped);
                    res.popped = popped;
                end else if (op == OP_REM && tid < NIL) begin
                    res.status = unlink_entry(qid, tid);
                end
            end
            return res;
        endfunction

        function void note_command(logic [1:0] op, logic [ID_W-1:0] qid, logic [ID_W-1:0] tid);
            outcome_t res;
            res = predict_outcome(op, qid, tid);
            pending_outcomes.push_back(res);
            if (res.status == STS_BAD) n_rejected++;
            else if (op == OP_ENQ) n_enq++;
            else if (op == OP_DEQ) n_deq++;
            else n_rem++;
            if (res.status == STS_OK) n_done++;
            if (res.status == STS_EMPTY) n_missing++;
            if (res.popped != NIL) n_pops++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [ID_W-1:0] popped, logic [1:0] status);
            outcome_t exp_res;
            n_checked++;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected result popped=%0d status=%0d",
                                          popped, status));
            end else begin
                exp_res = pending_outcomes.pop_front();
                if (popped !== exp_res.popped)
                    report_mismatch($sformatf("result %0d: popped_id %0d, expected %0d",
                                              n_checked, popped, exp_res.popped));
                if (status !== exp_res.status)
                    report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                              n_checked, status, exp_res.status));
            end
        endtask

        task check_leftovers();
            if (pending_outcomes.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_outcomes.size()));
        endtask

        // Mark which queue reaches each entry; unreached entries count as free.
        function void map_owners();
            logic [ID_W-1:0] cur;
            foreach (owner[i]) owner[i] = NIL;
            for (int qq = 0; qq <= NUM_ENTRIES; qq++) begin
                cur = q_first[qq];
                for (int k = 0; k < NUM_ENTRIES && cur != NIL; k++) begin
                    owner[cur[ENT_AW-1:0]] = ID_W'(qq);
                    cur = fwd_of(cur);
                end
            end
        endfunction
    endclass

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    logic [1:0]      s_op        = OP_ENQ;
    logic [ID_W-1:0] s_queue_id  = '0;
    logic [ID_W-1:0] s_thread_id = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    logic [ID_W-1:0] m_popped_id;
    logic [1:0]      m_status;

    lmq_tracker board = new();
    bit         hold_request = 1'b0;
    int         long_holds   = 0;
    int         burst_left   = 0;
    int         stall_count  = 0;

    linked_multi_queue_manager i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_queue_id  (s_queue_id),
        .s_thread_id (s_thread_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_popped_id (m_popped_id),
        .m_status    (m_status)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Check every result beat against the oldest outstanding prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_popped_id, m_status);
    end

    // Abort when neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no beat for %0d cycles", $time, stall_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: switch between randomly chosen stall patterns; on
    // request hold off completely for a long stretch so the block backs up.
    initial begin : receiver
        rx_mode_t mode;
        int       left;
        int       cyc;
        mode = RX_OPEN;
        left = 0;
        cyc  = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_request = 1'b0;
                long_holds++;
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    RX_OPEN:     m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_SLOW:     m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Drive one command beat; enter and leave at a falling edge.
    task automatic send_item(logic [1:0] op, logic [ID_W-1:0] qid, logic [ID_W-1:0] tid);
        s_valid     <= 1'b1;
        s_op        <= op;
        s_queue_id  <= qid;
        s_thread_id <= tid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(op, qid, tid);
        @(negedge aclk);
    endtask

    // Open a gap between bursts, then send the beat.
    task automatic issue(logic [1:0] op, logic [ID_W-1:0] qid, logic [ID_W-1:0] tid);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_item(op, qid, tid);
    endtask

    // Drop valid and wait until every predicted result has been returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.pending_outcomes.size() != 0);
    endtask

    // Bias toward a few queues so lists grow long and remove walks go deep.
    function automatic logic [ID_W-1:0] pick_queue();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return '0;
        if (r < 70) return ID_W'($urandom_range(1, 3));
        if (r < 80) return NIL;
        return ID_W'($urandom_range(0, NUM_ENTRIES));
    endfunction

    // Find a free (or a queued) entry, scanning from a random start.
    function automatic logic [ID_W-1:0] find_entry(bit want_free);
        int start;
        int idx;
        start = $urandom_range(0, NUM_ENTRIES - 1);
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            idx = (start + k) % NUM_ENTRIES;
            if ((board.owner[idx] == NIL) == want_free) return ID_W'(idx);
        end
        return NIL;
    endfunction

    // Mostly well-formed traffic on live lists; a little misuse and noise.
    task automatic random_item();
        int              r;
        int              n_free;
        logic [ID_W-1:0] ent;
        logic [1:0]      op;
        logic [ID_W-1:0] qid;
        logic [ID_W-1:0] tid;
        board.map_owners();
        n_free = 0;
        foreach (board.owner[i]) if (board.owner[i] == NIL) n_free++;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            op  = 2'($urandom_range(0, 3));
            qid = ID_W'($urandom_range(0, 127));
            tid = ID_W'($urandom_range(0, 127));
        end else if (r < 7) begin
            // enqueue regardless of whether the entry is already linked
            op  = OP_ENQ;
            qid = pick_queue();
            tid = ID_W'($urandom_range(0, NUM_ENTRIES - 1));
        end else if ($urandom_range(0, NUM_ENTRIES - 1) < n_free) begin
            op  = OP_ENQ;
            qid = pick_queue();
            tid = find_entry(1'b1);
        end else begin
            ent = find_entry(1'b0);
            qid = ($urandom_range(0, 9) == 0) ? pick_queue() : board.owner[ent[ENT_AW-1:0]];
            if ($urandom_range(0, 1) == 0) begin
                op  = OP_DEQ;
                tid = ID_W'($urandom_range(0, NUM_ENTRIES - 1));
            end else begin
                op  = OP_REM;
                tid = ent;
            end
        end
        issue(op, qid, tid);
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Rejected arguments: undefined op, queue ids past null, thread ids
        // at or past null.
        issue(OP_UNDEF, 7'd3,   7'd3);
        issue(OP_DEQ,   7'd65,  7'd0);
        issue(OP_ENQ,   7'd127, 7'd9);
        issue(OP_ENQ,   7'd4,   NIL);
        issue(OP_REM,   7'd4,   7'd127);

        // Enqueue into empty and onto a tail, at both ends of the id ranges.
        issue(OP_ENQ, 7'd0, 7'd0);
        issue(OP_ENQ, 7'd0, 7'd63);
        issue(OP_ENQ, 7'd0, 7'd2);
        issue(OP_ENQ, NIL,  7'd1);
        issue(OP_DEQ, 7'd1, 7'd0);    // empty queue
        issue(OP_REM, 7'd2, 7'd3);    // remove from an empty queue
        issue(OP_REM, NIL,  7'd5);    // single entry, not the one asked for
        issue(OP_REM, 7'd0, 7'd63);   // unlink from the middle
        issue(OP_REM, 7'd0, 7'd2);    // unlink the tail
        issue(OP_ENQ, 7'd0, 7'd63);
        issue(OP_REM, 7'd0, 7'd0);    // unlink the head of a longer list
        issue(OP_DEQ, 7'd0, 7'd0);    // pop the last entry
        issue(OP_DEQ, NIL,  7'd0);

        // Re-enqueue linked entries until a remove closes a self loop, then
        // walk the looping queue for an entry that is not there.
        issue(OP_ENQ, 7'd5, 7'd10);
        issue(OP_ENQ, 7'd5, 7'd11);
        issue(OP_ENQ, 7'd6, 7'd13);
        issue(OP_ENQ, 7'd6, 7'd12);
        issue(OP_ENQ, 7'd6, 7'd11);
        issue(OP_ENQ, 7'd6, 7'd12);
        issue(OP_REM, 7'd5, 7'd11);
        issue(OP_REM, 7'd6, 7'd63);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_request = 1'b1;
            if (n == 700) drain_results();
            random_item();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        board.check_leftovers();

        $display("Covered %0d enqueue, %0d dequeue, %0d remove and %0d rejected commands;",
                 board.n_enq, board.n_deq, board.n_rem, board.n_rejected);
        $display("%0d done, %0d empty or missing, %0d pops, deepest walk %0d, %0d long holds.",
                 board.n_done, board.n_missing, board.n_pops, board.deepest_walk,
                 long_holds);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lmq_pkg.sv
rtl/lmq_ram.sv
rtl/linked_multi_queue_manager.sv
rtl/lmq_checker.sv
tb/linked_multi_queue_manager_test.sv
